// ----- hw/rtl/iac_pkg.sv -----
`timescale 1ns / 1ps
// Package for the intrusion alarm controller: action and message codes,
// arm modes and the queue entry that the front end hands to the back end.
// No dependencies.
package iac_pkg;

    localparam int unsigned ActionWidth  = 4;
    localparam int unsigned MsgWidth     = 4;
    localparam int unsigned StatusWidth  = 2;
    localparam int unsigned PeriodWidth  = 16;
    localparam int unsigned HoldoffWidth = 17;
    localparam int unsigned CfgIndexWidth = 1;

    localparam logic [PeriodWidth-1:0] ResetTicks = 16'd1000;

    // Input actions.
    localparam logic [ActionWidth-1:0] ACT_TICK    = 4'd0;
    localparam logic [ActionWidth-1:0] ACT_DOOR    = 4'd1;
    localparam logic [ActionWidth-1:0] ACT_MOTION  = 4'd2;
    localparam logic [ActionWidth-1:0] ACT_TAMPER  = 4'd3;
    localparam logic [ActionWidth-1:0] ACT_BUTTON  = 4'd4;
    localparam logic [ActionWidth-1:0] ACT_ARM     = 4'd5;
    localparam logic [ActionWidth-1:0] ACT_DEFUSE  = 4'd6;
    localparam logic [ActionWidth-1:0] ACT_SOFTARM = 4'd7;
    localparam logic [ActionWidth-1:0] ACT_QUERY   = 4'd8;

    // Result message codes.
    localparam logic [MsgWidth-1:0] MSG_NONE    = 4'd0;
    localparam logic [MsgWidth-1:0] MSG_ALARM   = 4'd1;
    localparam logic [MsgWidth-1:0] MSG_ARM     = 4'd2;
    localparam logic [MsgWidth-1:0] MSG_SOFT    = 4'd3;
    localparam logic [MsgWidth-1:0] MSG_UNALARM = 4'd4;
    localparam logic [MsgWidth-1:0] MSG_UNARM   = 4'd5;
    localparam logic [MsgWidth-1:0] MSG_DOOR    = 4'd6;
    localparam logic [MsgWidth-1:0] MSG_MOTION  = 4'd7;
    localparam logic [MsgWidth-1:0] MSG_TAMPER  = 4'd8;
    localparam logic [MsgWidth-1:0] MSG_BUTTON  = 4'd9;
    localparam logic [MsgWidth-1:0] MSG_STATUS  = 4'd10;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CFG_FLASH_PERIOD = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_TAMPER_HOLD  = 1'd1;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_SOFT = 2'd2
    } t_mode;

    // One processed event: one or two messages and the LED level after it.
    typedef struct packed {
        logic [MsgWidth-1:0]    code0;
        logic [StatusWidth-1:0] status0;
        logic                   two;
        logic [MsgWidth-1:0]    code1;
        logic                   led;
    } t_entry;

endpackage

// ----- hw/rtl/iac_front.sv -----
`timescale 1ns / 1ps
// Front end: holds configuration and alarm state, classifies each event and
// builds one queue entry per accepted transaction. Uses iac_pkg.
module iac_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [iac_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [iac_pkg::PeriodWidth-1:0]      i_cfg_data,
    input  logic                                 i_accept,
    input  logic [iac_pkg::ActionWidth-1:0]      i_action,
    input  logic                                 i_pin_level,
    input  logic                                 i_query_kind,
    output iac_pkg::t_entry                      o_entry
);

    logic [iac_pkg::PeriodWidth-1:0]  r_flash_period;
    logic [iac_pkg::PeriodWidth-1:0]  r_holdoff_ticks;
    iac_pkg::t_mode                   r_mode, n_mode;
    logic                             r_alarm, n_alarm;
    logic                             r_led, n_led;
    logic [iac_pkg::PeriodWidth-1:0]  r_countdown, n_countdown;
    logic [iac_pkg::HoldoffWidth-1:0] r_holdoff, n_holdoff;
    iac_pkg::t_entry                  entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_period  <= iac_pkg::ResetTicks;
            r_holdoff_ticks <= iac_pkg::ResetTicks;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iac_pkg::CFG_FLASH_PERIOD: r_flash_period  <= i_cfg_data;
                iac_pkg::CFG_TAMPER_HOLD:  r_holdoff_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_alarm     = r_alarm;
        n_led       = r_led;
        n_countdown = r_countdown;
        n_holdoff   = r_holdoff;
        entry.code0   = iac_pkg::MSG_NONE;
        entry.status0 = '0;
        entry.two     = 1'b0;
        entry.code1   = iac_pkg::MSG_NONE;

        case (i_action)
            iac_pkg::ACT_TICK: begin
                if (r_alarm) begin
                    if (r_countdown <= iac_pkg::PeriodWidth'(1)) begin
                        n_led       = ~r_led;
                        n_countdown = r_flash_period;
                        entry.code0 = iac_pkg::MSG_ALARM;
                    end else begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                if (r_holdoff != '0) begin
                    n_holdoff = r_holdoff - 1'b1;
                end
            end
            iac_pkg::ACT_DOOR: begin
                if (i_pin_level && r_mode != iac_pkg::MODE_OFF && !r_alarm) begin
                    n_alarm     = 1'b1;
                    n_countdown = r_flash_period;
                end
                entry.code0 = iac_pkg::MSG_DOOR;
            end
            iac_pkg::ACT_MOTION: begin
                if (i_pin_level && r_mode == iac_pkg::MODE_FULL && !r_alarm) begin
                    n_alarm     = 1'b1;
                    n_countdown = r_flash_period;
                end
                entry.code0 = iac_pkg::MSG_MOTION;
            end
            iac_pkg::ACT_TAMPER: begin
                if (r_holdoff == '0) begin
                    entry.code0 = iac_pkg::MSG_TAMPER;
                    if (r_mode == iac_pkg::MODE_OFF) begin
                        n_mode      = iac_pkg::MODE_SOFT;
                        entry.two   = 1'b1;
                        entry.code1 = iac_pkg::MSG_SOFT;
                    end
                    n_holdoff = {1'b0, r_holdoff_ticks} + 1'b1;
                end
            end
            iac_pkg::ACT_BUTTON: begin
                entry.code0 = iac_pkg::MSG_BUTTON;
                if (i_pin_level) begin
                    n_mode      = iac_pkg::MODE_FULL;
                    entry.two   = 1'b1;
                    entry.code1 = iac_pkg::MSG_ARM;
                end
            end
            iac_pkg::ACT_ARM: begin
                n_mode      = iac_pkg::MODE_FULL;
                entry.code0 = iac_pkg::MSG_ARM;
            end
            iac_pkg::ACT_DEFUSE: begin
                n_mode = iac_pkg::MODE_OFF;
                if (r_alarm) begin
                    n_alarm     = 1'b0;
                    n_led       = 1'b0;
                    entry.code0 = iac_pkg::MSG_UNALARM;
                    entry.two   = 1'b1;
                    entry.code1 = iac_pkg::MSG_UNARM;
                end else begin
                    entry.code0 = iac_pkg::MSG_UNARM;
                end
            end
            iac_pkg::ACT_SOFTARM: begin
                n_mode      = iac_pkg::MODE_SOFT;
                entry.code0 = iac_pkg::MSG_SOFT;
            end
            iac_pkg::ACT_QUERY: begin
                entry.code0   = iac_pkg::MSG_STATUS;
                entry.status0 = i_query_kind ? r_mode : {1'b0, r_alarm};
            end
            default: ;
        endcase

        entry.led = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= iac_pkg::MODE_OFF;
            r_alarm     <= 1'b0;
            r_led       <= 1'b0;
            r_countdown <= '0;
            r_holdoff   <= '0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_alarm     <= n_alarm;
            r_led       <= n_led;
            r_countdown <= n_countdown;
            r_holdoff   <= n_holdoff;
        end
    end

    assign o_entry = entry;

endmodule

// ----- hw/rtl/iac_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of processed events between the front end
// and the back end, with the head entry visible. Uses iac_pkg.
module iac_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iac_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output iac_pkg::t_entry o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

    iac_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ----- hw/rtl/iac_back.sv -----
`timescale 1ns / 1ps
// Back end: takes queue entries and sends their messages one per cycle, while
// the receiver pops, through an output register. Uses iac_pkg.
module iac_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  iac_pkg::t_entry                   i_q_head,
    output logic                              o_q_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [iac_pkg::MsgWidth-1:0]      o_message_code,
    output logic [iac_pkg::StatusWidth-1:0]   o_status_value,
    output logic                              o_led_on,
    output logic                              o_last_of_run
);

    logic                             r_valid;
    logic [iac_pkg::MsgWidth-1:0]     r_code;
    logic [iac_pkg::StatusWidth-1:0]  r_status;
    logic                             r_led;
    logic                             r_last;
    // Second message of a two-message entry, waiting for the output register.
    logic                             r_pend;
    logic [iac_pkg::MsgWidth-1:0]     r_pend_code;
    logic                             r_pend_led;
    logic                             load;

    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !r_pend && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_q_valid;
                r_pend  <= i_q_valid && i_q_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_code   <= r_pend_code;
                r_status <= '0;
                r_led    <= r_pend_led;
                r_last   <= 1'b1;
            end else begin
                r_code      <= i_q_head.code0;
                r_status    <= i_q_head.status0;
                r_led       <= i_q_head.led;
                r_last      <= !i_q_head.two;
                r_pend_code <= i_q_head.code1;
                r_pend_led  <= i_q_head.led;
            end
        end
    end

    assign o_empty        = !r_valid;
    assign o_message_code = r_code;
    assign o_status_value = r_status;
    assign o_led_on       = r_led;
    assign o_last_of_run  = r_last;

endmodule

// ----- hw/rtl/intrusion_alarm_controller.sv -----
`timescale 1ns / 1ps
// Intrusion alarm controller top level: front end, event queue, back end.
// Depends on iac_pkg, iac_front, iac_queue and iac_back.
//
// Usage:
//   Input channel: drive action, pin_level and query_kind with push high; a
//   transaction completes at a clock edge where push is high and full is low.
//   Result channel: while empty is low the oldest message is on the result
//   ports; it is taken at a clock edge where pop is high. Every event yields
//   one or two messages; last_of_run marks the final one of an event.
//   Configuration: write flash period (index 0) or tamper hold-off (index 1)
//   with i_cfg_we; only while the block is idle.
//   Path: the first message of an event passes through the event queue and
//   then the output register; a receiver stall can hold it in either. Throughput:
//   one event per cycle for single-message events while the receiver pops; a
//   two-message event is sent one message per cycle through the output register.
//   Stalls: events keep being accepted while the receiver stalls until the
//   event queue (QUEUE_DEPTH entries) and output register fill, then full
//   rises. Reset disarms, clears alarm, LED and counters, and sets both
//   registers to 1000 ticks.
module intrusion_alarm_controller #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [iac_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [iac_pkg::PeriodWidth-1:0]      i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [iac_pkg::ActionWidth-1:0]      i_action,
    input  logic                                 i_pin_level,
    input  logic                                 i_query_kind,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [iac_pkg::MsgWidth-1:0]         o_message_code,
    output logic [iac_pkg::StatusWidth-1:0]      o_status_value,
    output logic                                 o_led_on,
    output logic                                 o_buzzer_on,
    output logic                                 o_last_of_run
);

    iac_pkg::t_entry entry;
    iac_pkg::t_entry head;
    logic            accept;
    logic            q_valid;
    logic            q_pop;
    logic            led;

    assign accept = push && !full;

    iac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_pin_level  (i_pin_level),
        .i_query_kind (i_query_kind),
        .o_entry      (entry)
    );

    iac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    iac_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_message_code (o_message_code),
        .o_status_value (o_status_value),
        .o_led_on       (led),
        .o_last_of_run  (o_last_of_run)
    );

    // The buzzer follows the LED.
    assign o_led_on    = led;
    assign o_buzzer_on = led;

endmodule

// ----- verif/tb_intrusion_alarm_controller.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for intrusion_alarm_controller: directed and random event traffic
// against a behavioral model of the arm, alarm, flash and tamper hold-off state.
// Depends on iac_pkg and the intrusion_alarm_controller RTL.
module tb_intrusion_alarm_controller;
    import iac_pkg::*;

    localparam int unsigned WatchdogLimit = 2000;

    typedef struct packed {
        logic [MsgWidth-1:0]    code;
        logic [StatusWidth-1:0] status;
        logic                   led;
        logic                   last;
    } t_expected_msg;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] i_cfg_index = CFG_FLASH_PERIOD;
    logic [PeriodWidth-1:0]   i_cfg_data = '0;
    logic                     push = 1'b0;
    logic                     full;
    logic [ActionWidth-1:0]   i_action = ACT_TICK;
    logic                     i_pin_level = 1'b0;
    logic                     i_query_kind = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [MsgWidth-1:0]      o_message_code;
    logic [StatusWidth-1:0]   o_status_value;
    logic                     o_led_on;
    logic                     o_buzzer_on;
    logic                     o_last_of_run;

    // Behavioral copy of the controller state and its registers.
    logic [PeriodWidth-1:0]   flash_period = ResetTicks;
    logic [PeriodWidth-1:0]   holdoff_ticks = ResetTicks;
    t_mode                    pred_mode = MODE_OFF;
    logic                     pred_alarm = 1'b0;
    logic                     pred_led = 1'b0;
    logic [PeriodWidth-1:0]   pred_countdown = '0;
    logic [HoldoffWidth-1:0]  pred_holdoff = '0;

    t_expected_msg            pending_msgs[$];
    int unsigned              events_sent = 0;
    int unsigned              burst_left = 0;
    int unsigned              mismatch_count = 0;
    int unsigned              idle_cycles = 0;
    int unsigned              rx_cycle = 0;
    int unsigned              rx_mode = 0;
    int unsigned              rx_hold = 0;

    intrusion_alarm_controller uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_pin_level    (i_pin_level),
        .i_query_kind   (i_query_kind),
        .empty          (empty),
        .pop            (pop),
        .o_message_code (o_message_code),
        .o_status_value (o_status_value),
        .o_led_on       (o_led_on),
        .o_buzzer_on    (o_buzzer_on),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advances the controller model by one event and queues the messages it emits.
    function automatic void step_alarm_model(input logic [ActionWidth-1:0] action,
                                             input logic level, input logic kind);
        logic [MsgWidth-1:0]    codes[$];
        logic [StatusWidth-1:0] answer;
        t_expected_msg          msg;
        answer = '0;
        case (action)
            ACT_TICK: begin
                if (pred_alarm) begin
                    if (pred_countdown <= 16'd1) begin
                        pred_led = ~pred_led;
                        pred_countdown = flash_period;
                        codes.push_back(MSG_ALARM);
                    end else begin
                        pred_countdown = pred_countdown - 16'd1;
                    end
                end
                if (pred_holdoff != '0) pred_holdoff = pred_holdoff - 17'd1;
            end
            ACT_DOOR: begin
                if (level && pred_mode != MODE_OFF && !pred_alarm) begin
                    pred_alarm = 1'b1;
                    pred_countdown = flash_period;
                end
                codes.push_back(MSG_DOOR);
            end
            ACT_MOTION: begin
                if (level && pred_mode == MODE_FULL && !pred_alarm) begin
                    pred_alarm = 1'b1;
                    pred_countdown = flash_period;
                end
                codes.push_back(MSG_MOTION);
            end
            ACT_TAMPER: begin
                if (pred_holdoff == '0) begin
                    codes.push_back(MSG_TAMPER);
                    if (pred_mode == MODE_OFF) begin
                        pred_mode = MODE_SOFT;
                        codes.push_back(MSG_SOFT);
                    end
                    pred_holdoff = {1'b0, holdoff_ticks} + 17'd1;
                end
            end
            ACT_BUTTON: begin
                codes.push_back(MSG_BUTTON);
                if (level) begin
                    pred_mode = MODE_FULL;
                    codes.push_back(MSG_ARM);
                end
            end
            ACT_ARM: begin
                pred_mode = MODE_FULL;
                codes.push_back(MSG_ARM);
            end
            ACT_DEFUSE: begin
                pred_mode = MODE_OFF;
                if (pred_alarm) begin
                    pred_alarm = 1'b0;
                    pred_led = 1'b0;
                    codes.push_back(MSG_UNALARM);
                end
                codes.push_back(MSG_UNARM);
            end
            ACT_SOFTARM: begin
                pred_mode = MODE_SOFT;
                codes.push_back(MSG_SOFT);
            end
            ACT_QUERY: begin
                answer = kind ? 2'(pred_mode) : {1'b0, pred_alarm};
                codes.push_back(MSG_STATUS);
            end
            default: begin
            end
        endcase
        if (codes.size() == 0) codes.push_back(MSG_NONE);
        foreach (codes[i]) begin
            msg.code = codes[i];
            msg.status = answer;
            msg.led = pred_led;
            msg.last = (i == codes.size() - 1);
            pending_msgs.push_back(msg);
        end
    endfunction

    // Sends one event. The sender works in bursts with random gaps, and push stays
    // high across back-to-back transactions inside a burst.
    task automatic send_event(input logic [ActionWidth-1:0] action, input logic level,
                              input logic kind);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_action <= action;
        i_pin_level <= level;
        i_query_kind <= kind;
        do @(posedge i_clk); while (full);
        step_alarm_model(action, level, kind);
        events_sent++;
    endtask

    // Stops the sender and waits until every expected message has come out.
    task automatic wait_for_quiet();
        push <= 1'b0;
        burst_left = 0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CfgIndexWidth-1:0] index,
                                input logic [PeriodWidth-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_FLASH_PERIOD) flash_period = value;
        else holdoff_ticks = value;
    endtask

    // Arming, a sensor edge, a run of ticks and usually a defuse.
    task automatic run_intrusion_scenario();
        int unsigned tick_max;
        case ($urandom_range(0, 3))
            0: send_event(ACT_ARM, 1'($urandom), 1'($urandom));
            1: send_event(ACT_SOFTARM, 1'($urandom), 1'($urandom));
            2: send_event(ACT_BUTTON, 1'b1, 1'($urandom));
            default: send_event(ACT_TAMPER, 1'($urandom), 1'($urandom));
        endcase
        repeat ($urandom_range(0, 3)) send_event(ACT_TICK, 1'($urandom), 1'($urandom));
        send_event($urandom_range(0, 1) ? ACT_DOOR : ACT_MOTION,
                   $urandom_range(0, 7) != 0, 1'($urandom));
        tick_max = (flash_period <= 12) ? 3 * flash_period + 2 : 20;
        repeat ($urandom_range(0, tick_max)) send_event(ACT_TICK, 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) == 0) send_event(ACT_QUERY, 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 4) == 0)
            send_event($urandom_range(0, 1) ? ACT_ARM : ACT_SOFTARM, 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 4) != 0) send_event(ACT_DEFUSE, 1'($urandom), 1'($urandom));
    endtask

    task automatic test_reset_state();
        send_event(ACT_QUERY, 1'b1, 1'b0);
        send_event(ACT_QUERY, 1'b0, 1'b1);
        send_event(ACT_TICK, 1'b1, 1'b1);
    endtask

    // Walks through every action with one-tick flash period and hold-off.
    task automatic test_directed_events();
        wait_for_quiet();
        write_config(CFG_FLASH_PERIOD, 16'd1);
        write_config(CFG_TAMPER_HOLD, 16'd1);
        send_event(ACT_DEFUSE, 1'b0, 1'b0);
        send_event(ACT_QUERY, 1'b0, 1'b0);
        send_event(ACT_QUERY, 1'b0, 1'b1);
        send_event(ACT_DOOR, 1'b1, 1'b0);
        send_event(ACT_BUTTON, 1'b0, 1'b0);
        send_event(ACT_BUTTON, 1'b1, 1'b0);
        send_event(ACT_MOTION, 1'b0, 1'b0);
        send_event(ACT_MOTION, 1'b1, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        // Soft arm while the alarm sounds leaves the alarm running.
        send_event(ACT_SOFTARM, 1'b0, 1'b0);
        send_event(ACT_QUERY, 1'b0, 1'b0);
        send_event(ACT_QUERY, 1'b0, 1'b1);
        send_event(ACT_DEFUSE, 1'b0, 1'b0);
        // A tamper edge soft-arms a disarmed block; the next one falls in the hold-off.
        send_event(ACT_TAMPER, 1'b0, 1'b0);
        send_event(ACT_TAMPER, 1'b1, 1'b1);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TICK, 1'b0, 1'b0);
        send_event(ACT_TAMPER, 1'b0, 1'b0);
        // In soft mode only the door raises the alarm.
        send_event(ACT_MOTION, 1'b1, 1'b0);
        send_event(ACT_DOOR, 1'b1, 1'b0);
        send_event(ACT_ARM, 1'b0, 1'b0);
        send_event(ACT_DEFUSE, 1'b0, 1'b0);
        send_event(4'd9, 1'b1, 1'b1);
        send_event(4'd15, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input logic [PeriodWidth-1:0] period,
                                       input logic [PeriodWidth-1:0] holdoff,
                                       input int unsigned count);
        int unsigned target;
        int unsigned pick;
        logic [ActionWidth-1:0] action;
        wait_for_quiet();
        write_config(CFG_FLASH_PERIOD, period);
        write_config(CFG_TAMPER_HOLD, holdoff);
        target = events_sent + count;
        while (events_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                run_intrusion_scenario();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) action = ACT_TICK;
                else if (pick < 95) action = 4'($urandom_range(1, 8));
                else action = 4'($urandom_range(9, 15));
                send_event(action, 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        t_expected_msg msg;
        if ((push && !full) || (pop && !empty)) idle_cycles = 0;
        else idle_cycles++;
        if (i_rst_n && pop && !empty) begin
            if (pending_msgs.size() == 0) begin
                $error("unexpected result transaction: message_code %0d", o_message_code);
                mismatch_count++;
            end else begin
                msg = pending_msgs.pop_front();
                if (o_message_code !== msg.code) begin
                    $error("message_code: expected %0d, actual %0d", msg.code, o_message_code);
                    mismatch_count++;
                end
                if (o_status_value !== msg.status) begin
                    $error("status_value: expected %0d, actual %0d", msg.status, o_status_value);
                    mismatch_count++;
                end
                if (o_led_on !== msg.led) begin
                    $error("led_on: expected %0d, actual %0d", msg.led, o_led_on);
                    mismatch_count++;
                end
                if (o_buzzer_on !== msg.led) begin
                    $error("buzzer_on: expected %0d, actual %0d", msg.led, o_buzzer_on);
                    mismatch_count++;
                end
                if (o_last_of_run !== msg.last) begin
                    $error("last_of_run: expected %0d, actual %0d", msg.last, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom);
            2: pop <= (rx_cycle % 4 == 0);
            default: begin
                if (rx_hold == 0) rx_hold = $urandom_range(1, 15);
                rx_hold--;
                pop <= (rx_hold == 0);
            end
        endcase
    end

    initial begin
        while (idle_cycles < WatchdogLimit) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_events();
        test_random_traffic(16'd1, 16'd1, 80);
        test_random_traffic(16'd2, 16'd3, 80);
        test_random_traffic(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 100);
        test_random_traffic(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 50);
        test_random_traffic(16'd65535, 16'd65535, 60);
        wait_for_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_msgs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
